/* hw/rtl/lsf_pkg.sv */
// ----------------------------------------------------------------------------
// lsf_pkg
// Shared types, constants and helpers for the line substring filter.
// ----------------------------------------------------------------------------
package lsf_pkg;

	// Window depth: longest pattern the block can find
	localparam int PatternMax = 16;
	// Pattern bytes held by the two 64-bit pattern registers
	localparam int PatternCap = 16;
	localparam int CntW       = $clog2(PatternMax + 1);
	localparam int LenW       = 5;
	localparam int IdxW       = 3;

	localparam logic [7:0] NewlineByte = 8'd10;
	localparam logic [7:0] UpperA      = 8'd65;
	localparam logic [7:0] UpperZ      = 8'd90;
	localparam logic [7:0] CaseOffset  = 8'd32;

	// Configuration register indexes
	typedef enum logic [IdxW-1:0] {
		REG_PAT_FIRST = 3'd0,
		REG_PAT_LAST  = 3'd1,
		REG_PAT_LEN   = 3'd2,
		REG_FOLD_CASE = 3'd3,
		REG_INVERT    = 3'd4
	} cfg_reg_t;

	// Live configuration as seen by the datapath
	typedef struct packed {
		logic [63:0]     pat_first;
		logic [63:0]     pat_last;
		logic [LenW-1:0] pat_len;
		logic            fold_case;
		logic            invert;
	} cfg_t;

	// Window control from the top level
	typedef struct packed {
		logic shift;
		logic line_end;
	} win_ctrl_t;

	// Map A-Z to a-z when folding is enabled
	function automatic logic [7:0] fold_byte(input logic [7:0] c, input logic en);
		logic [7:0] r;
		r = c;
		if (en && c >= UpperA && c <= UpperZ) begin
			r = c + CaseOffset;
		end
		return r;
	endfunction

endpackage

/* hw/rtl/line_substring_filter.sv */
// ----------------------------------------------------------------------------
// line_substring_filter
// Fixed-string line filter over a byte stream, one byte per cycle while no closing byte waits on a stalled receiver.
// ----------------------------------------------------------------------------
// Usage:
//   Bytes enter on the in_valid/in_ready channel with data_byte and
//   stream_end. A newline byte or a byte flagged stream_end closes a line;
//   each closed line yields one request on the out_valid/out_ready channel
//   with line_selected, line_number, any_selected and last_line. Other
//   bytes yield nothing.
//   Configuration goes through cfg_valid/cfg_ready with cfg_index and
//   cfg_data while the block is idle; cfg_ready is always high.
//   Path: a closing byte passes the input register, then the result register.
//   Throughput: one byte per cycle, set by the single input register
//   feeding the window compare and the result register.
//   When the receiver stalls, bytes that close no line keep flowing; a
//   closing byte waits in the input register until the result register
//   frees, and in_ready drops only then.
//   Reset clears the configuration, line counts and stream flags; no
//   clearing pass is needed.
// ----------------------------------------------------------------------------
module line_substring_filter
	import lsf_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cfg_valid,
	output logic            cfg_ready,
	input  logic [IdxW-1:0] cfg_index,
	input  logic [63:0]     cfg_data,
	input  logic            in_valid,
	output logic            in_ready,
	input  logic [7:0]      data_byte,
	input  logic            stream_end,
	output logic            out_valid,
	input  logic            out_ready,
	output logic            line_selected,
	output logic [31:0]     line_number,
	output logic            any_selected,
	output logic            last_line
);

	cfg_t       cfg;
	win_ctrl_t  win_ctrl;
	logic       hit;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       end_s1;

	logic        found_q;
	logic [31:0] line_ctr_q;
	logic        stream_hit_q;

	logic        valid_s2;
	logic        selected_s2;
	logic [31:0] number_s2;
	logic        any_s2;
	logic        last_s2;

	logic        line_end;
	logic        out_free;
	logic        fire;
	logic        sel_now;
	logic [31:0] ctr_inc;

	assign cfg_ready = 1'b1;

	lsf_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	// Stage 1 advance: lines that close need a free result slot
	assign line_end = (byte_s1 == NewlineByte) || end_s1;
	assign out_free = !valid_s2 || out_ready;
	assign fire     = valid_s1 && (!line_end || out_free);
	assign in_ready = !valid_s1 || fire;

	assign win_ctrl.shift    = fire;
	assign win_ctrl.line_end = line_end;

	lsf_window_match u_win (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctrl    (win_ctrl),
		.byte_in (byte_s1),
		.cfg     (cfg),
		.hit     (hit)
	);

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= data_byte;
			end_s1  <= stream_end;
		end
	end

	// Line result terms
	assign ctr_inc = line_ctr_q + 32'd1;
	assign sel_now = (found_q || hit) ^ cfg.invert;

	// Per-line and per-stream state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q      <= 1'b0;
			line_ctr_q   <= '0;
			stream_hit_q <= 1'b0;
		end else if (fire) begin
			if (line_end) begin
				found_q      <= 1'b0;
				line_ctr_q   <= end_s1 ? '0 : ctr_inc;
				stream_hit_q <= end_s1 ? 1'b0 : (stream_hit_q || sel_now);
			end else begin
				found_q <= found_q || hit;
			end
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (fire && line_end) begin
			valid_s2 <= 1'b1;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && line_end) begin
			selected_s2 <= sel_now;
			number_s2   <= ctr_inc;
			any_s2      <= stream_hit_q || sel_now;
			last_s2     <= end_s1;
		end
	end

	assign out_valid     = valid_s2;
	assign line_selected = selected_s2;
	assign line_number   = number_s2;
	assign any_selected  = any_s2;
	assign last_line     = last_s2;

endmodule

/* hw/rtl/lsf_cfg_regs.sv */
// ----------------------------------------------------------------------------
// lsf_cfg_regs
// Configuration register file; writes beyond the register list are dropped.
// ----------------------------------------------------------------------------
module lsf_cfg_regs
	import lsf_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	input  logic            wr_en,
	input  logic [IdxW-1:0] wr_index,
	input  logic [63:0]     wr_data,
	output cfg_t            cfg
);

	cfg_t cfg_q;

	// Register write decode
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			unique case (cfg_reg_t'(wr_index))
				REG_PAT_FIRST: cfg_q.pat_first <= wr_data;
				REG_PAT_LAST:  cfg_q.pat_last  <= wr_data;
				REG_PAT_LEN:   cfg_q.pat_len   <= wr_data[LenW-1:0];
				REG_FOLD_CASE: cfg_q.fold_case <= wr_data[0];
				REG_INVERT:    cfg_q.invert    <= wr_data[0];
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

/* hw/rtl/lsf_window_match.sv */
// ----------------------------------------------------------------------------
// lsf_window_match
// Sliding byte window of the current line and parallel pattern compare.
// ----------------------------------------------------------------------------
module lsf_window_match
	import lsf_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  win_ctrl_t  ctrl,
	input  logic [7:0] byte_in,
	input  cfg_t       cfg,
	output logic       hit
);

	logic [7:0]      window_q [PatternMax];
	logic [7:0]      window_nx [PatternMax];
	logic [CntW-1:0] count_q;
	logic [CntW-1:0] count_nx;
	logic [8*PatternCap-1:0] pat_bits;
	logic            len_bad;
	logic            all_eq;

	assign pat_bits = {cfg.pat_last, cfg.pat_first};

	// Window after the incoming byte enters; newest byte at position 0
	always_comb begin
		window_nx[0] = byte_in;
		for (int k = 1; k < PatternMax; k++) begin
			window_nx[k] = window_q[k-1];
		end
	end

	// Saturating byte count of the current line
	assign count_nx = (int'(count_q) < PatternMax) ? count_q + 1'b1 : count_q;

	// Position pos in use holds pattern byte len-1-pos
	always_comb begin
		logic [LenW-1:0] idx;
		logic [7:0]      pbyte;
		all_eq = 1'b1;
		for (int pos = 0; pos < PatternMax; pos++) begin
			idx   = cfg.pat_len - LenW'(pos) - LenW'(1);
			pbyte = pat_bits[8*int'(idx[3:0]) +: 8];
			if (pos < int'(cfg.pat_len)) begin
				if (fold_byte(window_nx[pos], cfg.fold_case) !=
				    fold_byte(pbyte, cfg.fold_case)) begin
					all_eq = 1'b0;
				end
			end
		end
	end

	assign len_bad = (int'(cfg.pat_len) > PatternMax) || (int'(cfg.pat_len) > PatternCap);

	// Empty pattern always hits; overlong never does
	always_comb begin
		if (cfg.pat_len == '0) begin
			hit = 1'b1;
		end else if (len_bad || int'(count_nx) < int'(cfg.pat_len)) begin
			hit = 1'b0;
		end else begin
			hit = all_eq;
		end
	end

	// Window shift; stale bytes are masked by the count
	always_ff @(posedge clk) begin
		if (ctrl.shift) begin
			for (int k = 0; k < PatternMax; k++) begin
				window_q[k] <= window_nx[k];
			end
		end
	end

	// Line byte count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (ctrl.shift) begin
			count_q <= ctrl.line_end ? '0 : count_nx;
		end
	end

endmodule
